/* src/schc_pkg.sv */
// Shared types, codes and reset values for the speed class cadence block.
`timescale 1ns / 1ps
package schc_pkg;

  // Ring depth default
  localparam int SMOOTH_DEPTH_DEF = 8;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int IVL_W   = 22;
  localparam int CFG_IW  = 3;

  // Movement classes
  typedef enum logic [1:0] {
    CLS_IDLE  = 2'd0,
    CLS_WALK  = 2'd1,
    CLS_CYCLE = 2'd2,
    CLS_DRIVE = 2'd3
  } cls_e;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_WALK_TO_CYCLE_UP    = 3'd0,
    REG_CYCLE_TO_DRIVE_UP   = 3'd1,
    REG_CYCLE_TO_WALK_DOWN  = 3'd2,
    REG_DRIVE_TO_CYCLE_DOWN = 3'd3,
    REG_WALKING_IVL         = 3'd4,
    REG_CYCLING_IVL         = 3'd5,
    REG_DRIVING_IVL         = 3'd6,
    REG_IDLE_IVL            = 3'd7
  } cfg_idx_e;

  // Reset values
  localparam logic [SPEED_W-1:0] RST_WALK_UP  = 16'd800;
  localparam logic [SPEED_W-1:0] RST_DRIVE_UP = 16'd2500;
  localparam logic [SPEED_W-1:0] RST_WALK_DN  = 16'd600;
  localparam logic [SPEED_W-1:0] RST_CYCLE_DN = 16'd2000;
  localparam logic [IVL_W-1:0]   RST_WALK_IVL  = 22'd10000;
  localparam logic [IVL_W-1:0]   RST_CYCLE_IVL = 22'd5000;
  localparam logic [IVL_W-1:0]   RST_DRIVE_IVL = 22'd2000;
  localparam logic [IVL_W-1:0]   RST_IDLE_IVL  = 22'd30000;

  // Hysteresis thresholds as one group
  typedef struct packed {
    logic [SPEED_W-1:0] walk_up;
    logic [SPEED_W-1:0] drive_up;
    logic [SPEED_W-1:0] walk_dn;
    logic [SPEED_W-1:0] cycle_dn;
  } thr_t;

endpackage

/* src/schc_ram.sv */
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module schc_ram #(
  parameter int Width = 16,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/schc_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module schc_div #(
  parameter int DivW = 20,
  parameter int DsrW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DsrW-1:0] rem_q;
  logic [DivW-1:0] quo_q;
  logic [DsrW:0]   trial;
  logic            q_bit;
  logic [DsrW:0]   diff;

  // Trial subtract of the next dividend bit
  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    q_bit = (trial >= {1'b0, divisor_i});
    diff  = trial - {1'b0, divisor_i};
  end

  // Shift register holds the dividend, then fills with quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_q <= busy_q && !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= q_bit ? diff[DsrW-1:0] : trial[DsrW-1:0];
        quo_q <= {quo_q[DivW-2:0], q_bit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/schc_cls.sv */
// Four-state hysteresis classifier on the smoothed speed.
`timescale 1ns / 1ps
module schc_cls
  import schc_pkg::*;
(
  input  logic [SPEED_W-1:0] speed_i,
  input  cls_e               prev_i,
  input  thr_t               thr_i,
  output cls_e               next_o
);

  logic ge_cyc;
  logic ge_drv;
  logic lt_walk;
  logic lt_cyc;

  // Threshold compares, applied as written
  always_comb begin
    ge_cyc  = (speed_i >= thr_i.walk_up);
    ge_drv  = (speed_i >= thr_i.drive_up);
    lt_walk = (speed_i < thr_i.walk_dn);
    lt_cyc  = (speed_i < thr_i.cycle_dn);
  end

  // Next class from the previous one
  always_comb begin
    case (prev_i)
      CLS_WALK: begin
        if (ge_cyc) next_o = ge_drv ? CLS_DRIVE : CLS_CYCLE;
        else        next_o = CLS_WALK;
      end
      CLS_CYCLE: begin
        if (ge_drv)       next_o = CLS_DRIVE;
        else if (lt_walk) next_o = CLS_WALK;
        else              next_o = CLS_CYCLE;
      end
      CLS_DRIVE: begin
        if (lt_cyc) next_o = lt_walk ? CLS_WALK : CLS_CYCLE;
        else        next_o = CLS_DRIVE;
      end
      default: begin
        if (ge_drv)      next_o = CLS_DRIVE;
        else if (ge_cyc) next_o = CLS_CYCLE;
        else             next_o = CLS_WALK;
      end
    endcase
  end

endmodule

/* src/speed_class_hysteresis_cadence_core.sv */
// Speed class cadence core: sample ring, serial mean, hysteresis class, interval.
// In-trip item: push into the ring, sum of the filled entries at one ring read per cycle,
//   division by the fill count at one quotient bit per cycle, class decision, then the
//   result waits in S_OUT until the output register is free. Outside a trip the item
//   goes from S_IDLE straight to S_OUT. No new sample is taken until the last result is
//   in the output register. Reset: defaults in all registers, class idle, ring empty.
`timescale 1ns / 1ps
module speed_class_hysteresis_cadence_core
  import schc_pkg::*;
#(
  parameter int SMOOTH_DEPTH = SMOOTH_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_idx_i,
  input  logic [IVL_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SPEED_W-1:0] speed_sample_i,
  input  logic               in_trip_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         move_class_o,
  output logic               class_changed_o,
  output logic [IVL_W-1:0]   interval_ms_o,
  output logic [SPEED_W-1:0] smoothed_speed_o
);

  localparam int AW = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
  localparam int CW = $clog2(SMOOTH_DEPTH + 1);
  localparam int SW = SPEED_W + CW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_CLS,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  thr_t             thr_q;
  logic [IVL_W-1:0] walk_ivl_q, cycle_ivl_q, drive_ivl_q, idle_ivl_q;

  // Ring bookkeeping
  logic [AW-1:0] wslot_q;
  logic [CW-1:0] fill_q;
  logic [CW-1:0] rd_idx_q;
  logic          pend_q;
  logic [SW-1:0] sum_q;

  // Result and output registers
  cls_e               class_q;
  logic [SPEED_W-1:0] smooth_q;
  logic               res_changed_q;
  logic [IVL_W-1:0]   res_ivl_q;
  logic               out_valid_q;
  logic [1:0]         out_class_q;
  logic               out_changed_q;
  logic [IVL_W-1:0]   out_ivl_q;
  logic [SPEED_W-1:0] out_smooth_q;

  // Datapath wires
  logic               in_xfer;
  logic               ring_we;
  logic [SPEED_W-1:0] ring_rdata;
  logic               sum_done;
  logic               div_done;
  logic [SW-1:0]      div_quo;
  cls_e               next_cls;
  logic [IVL_W-1:0]   next_ivl;
  logic               out_free;

  assign in_xfer  = in_valid_i && (state_q == S_IDLE);
  assign ring_we  = in_xfer && in_trip_i;
  assign sum_done = (state_q == S_SUM) && (rd_idx_q == fill_q) && !pend_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sample ring
  schc_ram #(
    .Width(SPEED_W),
    .Depth(SMOOTH_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(wslot_q),
    .wdata_i(speed_sample_i),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(ring_rdata)
  );

  // Serial mean: sum over fill count
  schc_div #(
    .DivW(SW),
    .DsrW(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sum_done),
    .dividend_i(sum_q),
    .divisor_i (fill_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Class decision on the mean
  schc_cls u_cls (
    .speed_i(smooth_q),
    .prev_i (class_q),
    .thr_i  (thr_q),
    .next_o (next_cls)
  );

  // Interval of the new class
  always_comb begin
    case (next_cls)
      CLS_WALK:  next_ivl = walk_ivl_q;
      CLS_CYCLE: next_ivl = cycle_ivl_q;
      CLS_DRIVE: next_ivl = drive_ivl_q;
      default:   next_ivl = idle_ivl_q;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.walk_up  <= RST_WALK_UP;
      thr_q.drive_up <= RST_DRIVE_UP;
      thr_q.walk_dn  <= RST_WALK_DN;
      thr_q.cycle_dn <= RST_CYCLE_DN;
      walk_ivl_q     <= RST_WALK_IVL;
      cycle_ivl_q    <= RST_CYCLE_IVL;
      drive_ivl_q    <= RST_DRIVE_IVL;
      idle_ivl_q     <= RST_IDLE_IVL;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_WALK_TO_CYCLE_UP:    thr_q.walk_up  <= cfg_wdata_i[SPEED_W-1:0];
        REG_CYCLE_TO_DRIVE_UP:   thr_q.drive_up <= cfg_wdata_i[SPEED_W-1:0];
        REG_CYCLE_TO_WALK_DOWN:  thr_q.walk_dn  <= cfg_wdata_i[SPEED_W-1:0];
        REG_DRIVE_TO_CYCLE_DOWN: thr_q.cycle_dn <= cfg_wdata_i[SPEED_W-1:0];
        REG_WALKING_IVL:         walk_ivl_q     <= cfg_wdata_i;
        REG_CYCLING_IVL:         cycle_ivl_q    <= cfg_wdata_i;
        REG_DRIVING_IVL:         drive_ivl_q    <= cfg_wdata_i;
        REG_IDLE_IVL:            idle_ivl_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer, ring state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      wslot_q       <= '0;
      fill_q        <= '0;
      rd_idx_q      <= '0;
      pend_q        <= 1'b0;
      sum_q         <= '0;
      class_q       <= CLS_IDLE;
      smooth_q      <= '0;
      res_changed_q <= 1'b0;
      res_ivl_q     <= '0;
      out_valid_q   <= 1'b0;
      out_class_q   <= '0;
      out_changed_q <= 1'b0;
      out_ivl_q     <= '0;
      out_smooth_q  <= '0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_trip_i) begin
              // push sample, then sum the filled entries
              wslot_q  <= (wslot_q == AW'(SMOOTH_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
              if (fill_q < CW'(SMOOTH_DEPTH)) fill_q <= fill_q + 1'b1;
              rd_idx_q <= '0;
              pend_q   <= 1'b0;
              sum_q    <= '0;
              state_q  <= S_SUM;
            end else begin
              // leaving a trip drops a non-idle class and empties the ring
              smooth_q      <= '0;
              res_changed_q <= (class_q != CLS_IDLE);
              res_ivl_q     <= idle_ivl_q;
              if (class_q != CLS_IDLE) begin
                class_q <= CLS_IDLE;
                wslot_q <= '0;
                fill_q  <= '0;
              end
              state_q <= S_OUT;
            end
          end
        end
        S_SUM: begin
          // one ring entry per cycle, read data is registered and lags the address
          if (pend_q) sum_q <= sum_q + SW'(ring_rdata);
          if (rd_idx_q != fill_q) begin
            rd_idx_q <= rd_idx_q + 1'b1;
            pend_q   <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (sum_done) state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            smooth_q <= div_quo[SPEED_W-1:0];
            state_q  <= S_CLS;
          end
        end
        S_CLS: begin
          res_changed_q <= (next_cls != class_q);
          res_ivl_q     <= next_ivl;
          class_q       <= next_cls;
          state_q       <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_class_q   <= class_q;
            out_changed_q <= res_changed_q;
            out_ivl_q     <= res_ivl_q;
            out_smooth_q  <= smooth_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign move_class_o     = out_class_q;
  assign class_changed_o  = out_changed_q;
  assign interval_ms_o    = out_ivl_q;
  assign smoothed_speed_o = out_smooth_q;

endmodule

/* tb/schc_cadence_checker.sv */
// Transfer monitor, class and cadence predictor and scoreboard for the speed class core.
`timescale 1ns / 1ps
module schc_cadence_checker
  import schc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_idx_i,
  input  logic [IVL_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [SPEED_W-1:0] speed_sample_i,
  input  logic               in_trip_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         move_class_i,
  input  logic               class_changed_i,
  input  logic [IVL_W-1:0]   interval_ms_i,
  input  logic [SPEED_W-1:0] smoothed_speed_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        pending_o
);

  // One result transfer
  typedef struct packed {
    cls_e               move_class;
    logic               changed;
    logic [IVL_W-1:0]   interval;
    logic [SPEED_W-1:0] smoothed;
  } cadence_t;

  // Shadow of the configuration and of the classifier state
  thr_t               thr;
  logic [IVL_W-1:0]   ivl [4];
  logic [SPEED_W-1:0] ring [SMOOTH_DEPTH_DEF];
  int unsigned        wr_slot;
  int unsigned        fill;
  cls_e               cur_cls;

  cadence_t cadence_due [$];

  // Hysteresis step, thresholds compared exactly as configured
  function automatic cls_e pick_class(logic [SPEED_W-1:0] spd, cls_e prev);
    case (prev)
      CLS_WALK: begin
        if (spd >= thr.walk_up) return (spd < thr.drive_up) ? CLS_CYCLE : CLS_DRIVE;
        return CLS_WALK;
      end
      CLS_CYCLE: begin
        if (spd >= thr.drive_up) return CLS_DRIVE;
        if (spd < thr.walk_dn) return CLS_WALK;
        return CLS_CYCLE;
      end
      CLS_DRIVE: begin
        if (spd < thr.cycle_dn) return (spd < thr.walk_dn) ? CLS_WALK : CLS_CYCLE;
        return CLS_DRIVE;
      end
      default: begin
        if (spd >= thr.drive_up) return CLS_DRIVE;
        if (spd >= thr.walk_up) return CLS_CYCLE;
        return CLS_WALK;
      end
    endcase
  endfunction

  // Advance the shadow state by one sample and return the result it causes
  function automatic cadence_t predict_cadence(logic [SPEED_W-1:0] spd, logic trip);
    cadence_t          res;
    logic [SPEED_W+3:0] sum;
    cls_e              nxt;
    res = '0;
    if (trip) begin
      ring[wr_slot] = spd;
      wr_slot = (wr_slot + 1) % SMOOTH_DEPTH_DEF;
      if (fill < SMOOTH_DEPTH_DEF) fill++;
      // ring is cleared from slot 0, so the filled entries are the low ones
      sum = '0;
      for (int i = 0; i < fill; i++) sum += ring[i];
      res.smoothed = SPEED_W'(sum / fill);
      nxt = pick_class(res.smoothed, cur_cls);
      if (nxt != cur_cls) begin
        cur_cls = nxt;
        res.changed = 1'b1;
      end
    end else if (cur_cls != CLS_IDLE) begin
      // leaving a trip drops to idle and empties the ring
      cur_cls = CLS_IDLE;
      res.changed = 1'b1;
      wr_slot = 0;
      fill = 0;
    end
    res.move_class = cur_cls;
    res.interval = ivl[cur_cls];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cadence_t got;
    cadence_t exp_res;
    if (!rst_ni) begin
      thr.walk_up      = RST_WALK_UP;
      thr.drive_up     = RST_DRIVE_UP;
      thr.walk_dn      = RST_WALK_DN;
      thr.cycle_dn     = RST_CYCLE_DN;
      ivl[CLS_IDLE]    = RST_IDLE_IVL;
      ivl[CLS_WALK]    = RST_WALK_IVL;
      ivl[CLS_CYCLE]   = RST_CYCLE_IVL;
      ivl[CLS_DRIVE]   = RST_DRIVE_IVL;
      wr_slot          = 0;
      fill             = 0;
      cur_cls          = CLS_IDLE;
      cadence_due.delete();
      mismatch_cnt_o   = 0;
    end else begin
      // register writes, thresholds keep the low 16 bits
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_WALK_TO_CYCLE_UP:    thr.walk_up  = cfg_wdata_i[SPEED_W-1:0];
          REG_CYCLE_TO_DRIVE_UP:   thr.drive_up = cfg_wdata_i[SPEED_W-1:0];
          REG_CYCLE_TO_WALK_DOWN:  thr.walk_dn  = cfg_wdata_i[SPEED_W-1:0];
          REG_DRIVE_TO_CYCLE_DOWN: thr.cycle_dn = cfg_wdata_i[SPEED_W-1:0];
          REG_WALKING_IVL:         ivl[CLS_WALK]  = cfg_wdata_i;
          REG_CYCLING_IVL:         ivl[CLS_CYCLE] = cfg_wdata_i;
          REG_DRIVING_IVL:         ivl[CLS_DRIVE] = cfg_wdata_i;
          REG_IDLE_IVL:            ivl[CLS_IDLE]  = cfg_wdata_i;
          default: ;
        endcase
      end

      // result transfer against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        got.move_class = cls_e'(move_class_i);
        got.changed    = class_changed_i;
        got.interval   = interval_ms_i;
        got.smoothed   = smoothed_speed_i;
        if (cadence_due.size() == 0) begin
          $display("%0t: unexpected result: class %0d changed %0b interval %0d speed %0d",
                   $time, move_class_i, class_changed_i, interval_ms_i, smoothed_speed_i);
          mismatch_cnt_o++;
        end else begin
          exp_res = cadence_due.pop_front();
          if (got !== exp_res) begin
            $display("%0t: mismatch: expected class %0d changed %0b interval %0d speed %0d",
                     $time, exp_res.move_class, exp_res.changed, exp_res.interval,
                     exp_res.smoothed);
            $display("%0t:           actual   class %0d changed %0b interval %0d speed %0d",
                     $time, move_class_i, class_changed_i, interval_ms_i, smoothed_speed_i);
            mismatch_cnt_o++;
          end
        end
      end

      // sample transfer
      if (in_valid_i && !in_stall_i)
        cadence_due.push_back(predict_cadence(speed_sample_i, in_trip_i));
    end
    pending_o = cadence_due.size();
  end

endmodule

/* tb/tb_speed_class_hysteresis_cadence_core.sv */
// Testbench top for the speed class cadence core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_speed_class_hysteresis_cadence_core
  import schc_pkg::*;
();

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 255;
  localparam int unsigned TAIL_CYCLES  = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_IW-1:0]  cfg_idx_i;
  logic [IVL_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [SPEED_W-1:0] speed_sample_i;
  logic               in_trip_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         move_class_o;
  logic               class_changed_o;
  logic [IVL_W-1:0]   interval_ms_o;
  logic [SPEED_W-1:0] smoothed_speed_o;

  int unsigned mismatch_cnt;
  int unsigned pending;
  bit          tx_calm;

  speed_class_hysteresis_cadence_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .speed_sample_i   (speed_sample_i),
    .in_trip_i        (in_trip_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .move_class_o     (move_class_o),
    .class_changed_o  (class_changed_o),
    .interval_ms_o    (interval_ms_o),
    .smoothed_speed_o (smoothed_speed_o)
  );

  schc_cadence_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .speed_sample_i   (speed_sample_i),
    .in_trip_i        (in_trip_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .move_class_i     (move_class_o),
    .class_changed_i  (class_changed_o),
    .interval_ms_i    (interval_ms_o),
    .smoothed_speed_i (smoothed_speed_o),
    .mismatch_cnt_o   (mismatch_cnt),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offer one sample after a random gap and hold it until the transfer
  task automatic send_item(input logic [SPEED_W-1:0] spd, input logic trip);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    speed_sample_i <= spd;
    in_trip_i      <= trip;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [IVL_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Threshold write with junk in the bits above the register width
  function automatic logic [IVL_W-1:0] thr_word(input int unsigned val);
    return {6'($urandom_range(0, 63)), 16'(val)};
  endfunction

  // Settings per phase: ordered, all zero, unordered, all ones
  task automatic configure(input int phase);
    int unsigned wdn, wup, cdn, dup;
    case (phase)
      1: begin
        write_reg(REG_WALK_TO_CYCLE_UP,    '0);
        write_reg(REG_CYCLE_TO_DRIVE_UP,   '0);
        write_reg(REG_CYCLE_TO_WALK_DOWN,  '0);
        write_reg(REG_DRIVE_TO_CYCLE_DOWN, '0);
        write_reg(REG_WALKING_IVL,         '0);
        write_reg(REG_CYCLING_IVL,         '0);
        write_reg(REG_DRIVING_IVL,         '0);
        write_reg(REG_IDLE_IVL,            '0);
      end
      2: begin
        write_reg(REG_WALK_TO_CYCLE_UP,    thr_word($urandom_range(0, 6000)));
        write_reg(REG_CYCLE_TO_DRIVE_UP,   thr_word($urandom_range(0, 6000)));
        write_reg(REG_CYCLE_TO_WALK_DOWN,  thr_word($urandom_range(0, 6000)));
        write_reg(REG_DRIVE_TO_CYCLE_DOWN, thr_word($urandom_range(0, 6000)));
        write_reg(REG_WALKING_IVL,         IVL_W'($urandom()));
        write_reg(REG_CYCLING_IVL,         IVL_W'($urandom()));
        write_reg(REG_DRIVING_IVL,         IVL_W'($urandom()));
        write_reg(REG_IDLE_IVL,            IVL_W'($urandom()));
      end
      4: begin
        write_reg(REG_WALK_TO_CYCLE_UP,    '1);
        write_reg(REG_CYCLE_TO_DRIVE_UP,   '1);
        write_reg(REG_CYCLE_TO_WALK_DOWN,  '1);
        write_reg(REG_DRIVE_TO_CYCLE_DOWN, '1);
        write_reg(REG_WALKING_IVL,         '1);
        write_reg(REG_CYCLING_IVL,         '1);
        write_reg(REG_DRIVING_IVL,         '1);
        write_reg(REG_IDLE_IVL,            '1);
      end
      default: begin
        wdn = $urandom_range(0, 1500);
        wup = wdn + $urandom_range(0, 1000);
        cdn = wup + $urandom_range(0, 2500);
        dup = cdn + $urandom_range(0, 2000);
        write_reg(REG_WALK_TO_CYCLE_UP,    thr_word(wup));
        write_reg(REG_CYCLE_TO_DRIVE_UP,   thr_word(dup));
        write_reg(REG_CYCLE_TO_WALK_DOWN,  thr_word(wdn));
        write_reg(REG_DRIVE_TO_CYCLE_DOWN, thr_word(cdn));
        write_reg(REG_WALKING_IVL,         IVL_W'($urandom_range(0, 3600000)));
        write_reg(REG_CYCLING_IVL,         IVL_W'($urandom_range(0, 3600000)));
        write_reg(REG_DRIVING_IVL,         IVL_W'($urandom_range(0, 3600000)));
        write_reg(REG_IDLE_IVL,            IVL_W'($urandom_range(0, 3600000)));
      end
    endcase
  endtask

  // Mostly near the trip's base speed, sometimes full range or the extremes
  function automatic logic [SPEED_W-1:0] draw_speed(input int base);
    int v;
    case ($urandom_range(0, 15))
      0:       v = $urandom_range(0, 65535);
      1:       v = 65535;
      2:       v = 0;
      default: v = base + int'($urandom_range(0, 1200)) - 600;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[SPEED_W-1:0];
  endfunction

  // Trips of random length with a drifting speed, then a few items outside a trip
  task automatic run_trips(input int unsigned quota);
    int unsigned sent;
    int unsigned len;
    int          base;
    sent = 0;
    while (sent < quota) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      base    = $urandom_range(0, 7000);
      len     = $urandom_range(1, 24);
      repeat (len) begin
        base = base + int'($urandom_range(0, 400)) - 200;
        // now and then a stray item outside the trip
        send_item(draw_speed(base), $urandom_range(0, 15) != 0);
        sent++;
      end
      repeat ($urandom_range(1, 3)) begin
        send_item(draw_speed(base), 1'b0);
        sent++;
      end
    end
  endtask

  // Receiver: random stall before each transfer, calm stretches, one long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned taken;
    stall_left  = 0;
    taken       = 0;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        taken++;
        if (taken == HOLD_AT) stall_left = HOLD_CYCLES;
        else if ((taken / 64) % 4 == 3) stall_left = 0;
        else stall_left = $urandom_range(0, 13);
      end
    end
  end

  // Ends the run when no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("speed_class_hysteresis_cadence_core test failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    speed_sample_i = '0;
    in_trip_i      = 1'b0;
    tx_calm        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, default thresholds: idle stays idle outside a trip, climbs and falls
    send_item(16'hFFFF, 1'b0);
    send_item(16'd0,    1'b1);
    repeat (7) send_item(16'hFFFF, 1'b1);
    send_item(16'd0,    1'b1);   // ring wraps
    send_item(16'd0,    1'b0);   // driving to idle, ring emptied
    send_item(16'd900,  1'b1);   // idle to cycling
    send_item(16'd0,    1'b1);   // cycling to walking
    send_item(16'd700,  1'b1);
    send_item(16'd2400, 1'b1);   // walking to cycling
    send_item(16'd0,    1'b0);
    send_item(16'd0,    1'b0);
    send_item(16'd3000, 1'b1);   // idle to driving
    send_item(16'd1200, 1'b1);
    send_item(16'd0,    1'b1);   // driving to cycling
    send_item(16'd6000, 1'b1);   // cycling to driving
    send_item(16'd0,    1'b0);
    drain();

    // inconsistent thresholds and out-of-range intervals
    write_reg(REG_WALK_TO_CYCLE_UP,    '1);
    write_reg(REG_CYCLE_TO_DRIVE_UP,   '0);
    write_reg(REG_CYCLE_TO_WALK_DOWN,  '1);
    write_reg(REG_DRIVE_TO_CYCLE_DOWN, '1);
    write_reg(REG_WALKING_IVL,         '1);
    write_reg(REG_CYCLING_IVL,         '0);
    write_reg(REG_DRIVING_IVL,         IVL_W'(3600000));
    write_reg(REG_IDLE_IVL,            IVL_W'(1));
    send_item(16'd100,  1'b1);   // idle to driving at a zero threshold
    send_item(16'd100,  1'b1);   // driving straight to walking
    send_item(16'hFFFF, 1'b1);

    // random phases, each under its own settings
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      configure(phase);
      run_trips(PHASE_ITEMS);
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending == 0) begin
      $display("speed_class_hysteresis_cadence_core test passed");
    end else begin
      $display("speed_class_hysteresis_cadence_core test failed");
    end
    $finish;
  end

endmodule
